@@ sv/sha256_stream_hasher_macros.svh @@
// Assertion macros for the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
`ifndef SYNTHESIS
`define SSH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define SSH_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SSH_ASSERT(label, clk, rst_n, prop)
`define SSH_ASSERT_RST(label, clk, prop)
`endif
`endif

@@ sv/sha256_pkg.sv @@
// Package with SHA-256 constants, types and round functions.
`default_nettype none
package sha256_pkg;
  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

@@ sv/sha256_stream_hasher.sv @@
// Top level: byte collection, padding and digest output of the SHA-256 hasher.
// A byte that does not complete a block is stored; a byte that completes one starts a
// compression: a load step, 64 rounds, the fold and a hand-off, with no input taken.
// An end item pads the block one byte per cycle up to its end, runs one or two
// compressions and then gives 8 digest words, at most one per cycle.
// Reset loads the initial hash values and clears the fill and bit counters.
`default_nettype none
`include "sha256_stream_hasher_macros.svh"
module sha256_stream_hasher (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic [7:0] byte_value_i,
  input  wire logic byte_present_i,
  input  wire logic end_of_message_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0] word_number_o,
  output logic last_word_o
);
  import sha256_pkg::*;

  state_e state_q, state_d;
  logic [7:0] buf_q [64];
  logic [5:0] fill_q;
  logic [63:0] bits_q;
  logic fin_q, pad_q, len_q;
  logic [2:0] wn_q;
  logic in_accept;
  logic [7:0] pad_byte;
  logic core_start, core_busy, core_done, core_init;
  word_t hash [8];
  logic [511:0] blk;

  always_comb
    for (int i = 0; i < 64; i++) blk[511 - 8*i -: 8] = buf_q[i];

  assign core_start = (state_q == ST_LOAD);
  assign core_init = (state_q == ST_EMIT) && out_ready_i && (wn_q == 3'd7);

  sha256_core u_core (
    .clk_i, .rst_ni, .start_i(core_start), .init_i(core_init), .block_i(blk),
    .busy_o(core_busy), .done_o(core_done), .hash_o(hash)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (byte_present_i && fill_q == 6'd63) state_d = ST_LOAD;
          else if (end_of_message_i) state_d = ST_PAD;
        end
      end
      ST_PAD: if (fill_q == 6'd63) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_ROUND;
      ST_ROUND: if (core_done) state_d = ST_FOLD;
      ST_FOLD: begin
        if (!fin_q) state_d = ST_IDLE;
        else if (len_q) state_d = ST_EMIT;
        else state_d = ST_PAD;
      end
      ST_EMIT: if (out_ready_i && wn_q == 3'd7) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // The length goes into the last eight bytes of the block that holds it.
  always_comb begin
    if (!pad_q) pad_byte = PAD_BYTE;
    else if (len_q && fill_q >= LEN_POS) pad_byte = bits_q[{~fill_q[2:0], 3'b111} -: 8];
    else pad_byte = 8'h00;
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_EMIT);
  assign digest_word_o = hash[wn_q];
  assign word_number_o = wn_q;
  assign last_word_o = (wn_q == 3'd7);

  always_ff @(posedge clk_i) begin
    if (in_accept && byte_present_i) buf_q[fill_q] <= byte_value_i;
    else if (state_q == ST_PAD) buf_q[fill_q] <= pad_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q <= '0;
      bits_q <= '0;
      fin_q <= 1'b0;
      pad_q <= 1'b0;
      len_q <= 1'b0;
      wn_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        if (byte_present_i) begin
          fill_q <= fill_q + 6'd1;
          bits_q <= bits_q + 64'd8;
        end
        fin_q <= end_of_message_i;
      end else if (state_q == ST_PAD) begin
        fill_q <= fill_q + 6'd1;
        if (!pad_q) begin
          pad_q <= 1'b1;
          if (fill_q < LEN_POS) len_q <= 1'b1;
        end
      end else if (state_q == ST_FOLD && fin_q && !len_q) begin
        len_q <= 1'b1;
      end else if (state_q == ST_EMIT && out_ready_i) begin
        wn_q <= wn_q + 3'd1;
        if (wn_q == 3'd7) begin
          fin_q <= 1'b0;
          pad_q <= 1'b0;
          len_q <= 1'b0;
          bits_q <= '0;
        end
      end
    end
  end

  `SSH_ASSERT(a_no_accept_busy, clk_i, rst_ni, core_busy |-> !in_ready_o)
  `SSH_ASSERT(a_emit_after_fin, clk_i, rst_ni, out_valid_o |-> fin_q && pad_q && len_q)
  `SSH_ASSERT(a_pad_fin, clk_i, rst_ni, (state_q == ST_PAD) |-> fin_q)
  `SSH_ASSERT(a_last_idle, clk_i, rst_ni,
    (out_valid_o && out_ready_i && last_word_o) |=> state_q == ST_IDLE)
endmodule
`default_nettype wire

@@ sv/sha256_core.sv @@
// Iterative SHA-256 compression unit, one round per cycle.
`default_nettype none
`include "sha256_stream_hasher_macros.svh"
module sha256_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic init_i,
  input  wire logic [511:0] block_i,
  output logic busy_o,
  output logic done_o,
  output sha256_pkg::word_t hash_o [8]
);
  import sha256_pkg::*;

  word_t h_q [8];
  word_t v_q [8];
  word_t w_q [16];
  logic [5:0] rnd_q;
  logic busy_q, fold_q, done_q;
  word_t w_cur, w_new, t1, t2, s0, s1;

  always_comb begin
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = s1 + w_q[9] + s0 + w_q[0];
    w_cur = (rnd_q < 6'd16) ? w_q[0] : w_new;
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25)) +
         ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[rnd_q] + w_cur;
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) +
         ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fold_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
    end else begin
      done_q <= 1'b0;
      if (init_i) begin
        for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
      end
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        rnd_q <= '0;
        for (int i = 0; i < 16; i++) w_q[i] <= block_i[511 - 32*i -: 32];
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end else if (fold_q) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        fold_q <= 1'b0;
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else if (busy_q) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= w_cur;
        v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) fold_q <= 1'b1;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign hash_o = h_q;

  `SSH_ASSERT(a_done_after_fold, clk_i, rst_ni, fold_q |=> done_q)
  `SSH_ASSERT(a_fold_busy, clk_i, rst_ni, fold_q |-> busy_q)
  `SSH_ASSERT(a_done_idle, clk_i, rst_ni, done_q |-> !busy_q)
endmodule
`default_nettype wire

@@ test/sha256_stream_hasher_tb.sv @@
// Self-checking testbench for the SHA-256 stream hasher: random messages, digests predicted.
`timescale 1ns / 1ps
module sha256_stream_hasher_tb;
  import sha256_pkg::*;

  class digest_scoreboard;
    word_t chain[8];
    logic [7:0] blk[64];
    int unsigned fill;
    logic [63:0] bit_count;
    word_t exp_word[$];
    logic [2:0] exp_num[$];
    logic exp_last[$];
    int unsigned errors;
    int unsigned words_seen;

    function new();
      chain = H_INIT;
      fill = 0;
      bit_count = 0;
      errors = 0;
      words_seen = 0;
    endfunction

    function word_t rr(word_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      word_t w[16];
      word_t v[8];
      word_t nw, t1, t2, a, b;
      for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      v = chain;
      for (int r = 0; r < 64; r++) begin
        if (r < 16) begin
          nw = w[r];
        end else begin
          a = w[(r - 2) & 15];
          b = w[(r - 15) & 15];
          nw = (rr(a, 17) ^ rr(a, 19) ^ (a >> 10)) + w[(r - 7) & 15] +
               (rr(b, 7) ^ rr(b, 18) ^ (b >> 3)) + w[r & 15];
          w[r & 15] = nw;
        end
        t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + nw;
        t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void note_item(logic [7:0] value, logic present, logic eom);
      int unsigned i;
      if (present) begin
        blk[fill] = value;
        fill++;
        bit_count += 64'd8;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!eom) return;
      i = fill;
      blk[i++] = PAD_BYTE;
      if (i > LEN_POS) begin
        while (i < 64) blk[i++] = 8'h00;
        compress();
        i = 0;
      end
      while (i < LEN_POS) blk[i++] = 8'h00;
      for (int k = 0; k < 8; k++) blk[LEN_POS + k] = bit_count[63 - 8*k -: 8];
      compress();
      for (int k = 0; k < 8; k++) begin
        exp_word.push_back(chain[k]);
        exp_num.push_back(k[2:0]);
        exp_last.push_back(k == 7);
      end
      chain = H_INIT;
      fill = 0;
      bit_count = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_word(word_t word, logic [2:0] num, logic last);
      words_seen++;
      if (exp_word.size() == 0) begin
        report("unexpected digest word", word, 0);
        return;
      end
      if (word !== exp_word[0]) report("digest_word", word, exp_word[0]);
      if (num !== exp_num[0]) report("word_number", num, exp_num[0]);
      if (last !== exp_last[0]) report("last_word", last, exp_last[0]);
      void'(exp_word.pop_front());
      void'(exp_num.pop_front());
      void'(exp_last.pop_front());
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [7:0] byte_value_i = 8'h00;
  logic byte_present_i = 1'b0;
  logic end_of_message_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, last_word_o;
  logic [31:0] digest_word_o;
  logic [2:0] word_number_o;

  digest_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit hold_off = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned messages_sent = 0;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  sha256_stream_hasher dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_item(byte_value_i, byte_present_i,
                                                         end_of_message_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word(digest_word_o, word_number_o, last_word_o);
  end

  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(logic [7:0] value, logic present, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_value_i <= value;
    byte_present_i <= present;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (eom) messages_sent++;
  endtask

  task automatic send_message(int unsigned len, bit end_with_byte);
    for (int unsigned i = 0; i < len; i++)
      send_item($urandom_range(255), 1'b1, end_with_byte && (i == len - 1));
    if (!end_with_byte || len == 0) send_item($urandom_range(255), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned len;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    send_message(119, 1'b1);
    send_message(64, 1'b1);

    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_message(56, 1'b0);
        send_message(3, 1'b0);
      end
    join

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 37 : 65) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 37 : 65) : 0;
      for (int m = 0; m < 3; m++) begin
        len = $urandom_range(4);
        if ($urandom_range(9) == 0) begin
          send_item($urandom_range(255), 1'b0, 1'b0);
        end
        send_message(len, $urandom_range(1));
      end
    end
    in_valid_i <= 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;

    while (sb.exp_word.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Covered empty, short and multi-block messages, both padding layouts,");
    $display("a long output stall, and %0d items in %0d messages with %0d words checked.",
             items_sent, messages_sent, sb.words_seen);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+sv
sv/sha256_pkg.sv
sv/sha256_core.sv
sv/sha256_stream_hasher.sv
test/sha256_stream_hasher_tb.sv
